>>> rtl/fat_tree_route_port_select_macros.svh
// assertion macros for the fat-tree route port selector
`ifndef FAT_TREE_ROUTE_PORT_SELECT_MACROS_SVH
`define FAT_TREE_ROUTE_PORT_SELECT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, sampled on clk, off while in reset
`define FTRPS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fat_tree_route_port_select check failed");
// next-cycle implication, sampled on clk, off while in reset
`define FTRPS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fat_tree_route_port_select check failed");
`else
`define FTRPS_ASSERT_NOW(label, ante, cons)
`define FTRPS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> rtl/ftrps_pkg.sv
// shared types and constants for the fat-tree route port selector
package ftrps_pkg;

    localparam int MAX_PORTS  = 16;
    localparam int MAX_VCS    = 4;
    localparam int NODE_BITS  = 16;
    localparam int BUF_BITS   = 10;

    localparam int BUF_DEPTH  = MAX_PORTS * MAX_VCS;
    localparam int ADDR_W     = $clog2(BUF_DEPTH);
    localparam int IDX_W      = ADDR_W + 1;
    localparam int PORT_W     = $clog2(MAX_PORTS);
    localparam int VC_W       = $clog2(MAX_VCS);
    localparam int NPORT_W    = $clog2(MAX_PORTS) + 1;
    localparam int NVC_W      = $clog2(MAX_VCS) + 1;
    localparam int FAN_W      = $clog2(MAX_PORTS / 2) + 1;
    localparam int SUM_W      = BUF_BITS + $clog2(MAX_VCS);

    localparam int DIVIDEND_W = NODE_BITS + FAN_W;
    localparam int DIVISOR_W  = NODE_BITS;
    localparam int DIV_CNT_W  = $clog2(DIVIDEND_W + 1);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_PORTS       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VCS_PER_PORT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ADAPTIVE_MODE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_BUFFERING = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_START     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_END       = 3'd5;

    // item opcodes
    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_ROUTE  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_CAND,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic                 opcode;
        logic [NODE_BITS-1:0] src_node;
        logic [NODE_BITS-1:0] dst_node;
        logic [PORT_W-1:0]    in_port;
        logic [PORT_W-1:0]    upd_port;
        logic [VC_W-1:0]      upd_vc;
        logic [BUF_BITS-1:0]  upd_value;
    } req_item_t;

    typedef struct packed {
        logic [PORT_W-1:0] out_port;
        logic              route_error;
    } rsp_item_t;

    typedef struct packed {
        logic                en;
        logic [ADDR_W-1:0]   addr;
        logic [BUF_BITS-1:0] data;
    } buf_wr_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } buf_rd_t;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic                  busy;
        logic                  done;
        logic [DIVIDEND_W-1:0] quotient;
        logic [DIVISOR_W-1:0]  remainder;
    } div_rsp_t;

    // bookkeeping that travels alongside one buffer read
    typedef struct packed {
        logic              valid;
        logic              cand;
        logic [PORT_W-1:0] port;
        logic              first_vc;
        logic              last_vc;
        logic              last;
    } scan_tag_t;

endpackage

>>> rtl/fat_tree_route_port_select.sv
// top level: fat-tree up/down output port selector
//
// req channel (req_valid/req_stall/req_data) carries update and route items.
// an update writes one free-buffer count: the next item can transfer on the
// following clock. a route item holds req_stall high until its result is
// formed:
//   static up path: in_port + fanout, with no divider or scan
//   down path: set by the 20-step shared divider
//   adaptive up, port sums: a scan of N buffer reads, N = upper ports * vcs
//   adaptive up, single vcs: the divider for the first candidate, then the
//   scan; N is at most 32 with one buffer read a cycle
// rsp channel (rsp_valid/rsp_stall/rsp_data) returns one result per route
// item from an output register; a stalled result holds while the next item
// is already being worked on, and the block waits only if a second result
// is ready before the first has gone.
// cfg channel writes one register per transfer, always ready; write only
// while the block is idle.
// reset sets the config registers to defaults and all buffer counts to zero
// at once through per-entry valid bits, so no clearing pass is needed.
`include "fat_tree_route_port_select_macros.svh"

module fat_tree_route_port_select
    import ftrps_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // item channel
    input  logic                  req_valid,
    output logic                  req_stall,
    input  req_item_t             req_data,
    // result channel
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output rsp_item_t             rsp_data,
    // config write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // config registers
    logic [NPORT_W-1:0]   num_ports_reg;
    logic [NVC_W-1:0]     vcs_reg;
    logic                 adaptive_reg;
    logic                 ibuf_reg;
    logic [NODE_BITS-1:0] range_start_reg;
    logic [NODE_BITS-1:0] range_end_reg;

    // sequencer and datapath state
    state_t               state_reg, state_next;
    req_item_t            item_reg, item_next;
    scan_tag_t            tag_reg, tag_next;
    logic                 down_reg, down_next;
    logic                 neg_reg, neg_next;
    logic [PORT_W-1:0]    cand_reg, cand_next;
    logic [PORT_W-1:0]    scan_port_reg, scan_port_next;
    logic [VC_W-1:0]      scan_vc_reg, scan_vc_next;
    logic [ADDR_W-1:0]    scan_addr_reg, scan_addr_next;
    logic [SUM_W-1:0]     acc_reg, acc_next;
    logic [SUM_W-1:0]     best_reg, best_next;
    logic [PORT_W-1:0]    best_port_reg, best_port_next;
    logic [PORT_W-1:0]    res_port_reg, res_port_next;
    logic                 res_err_reg, res_err_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    rsp_item_t            rsp_data_reg, rsp_data_next;

    // effective config
    logic [NPORT_W-1:0]   ports_eff;
    logic [NVC_W-1:0]     vcs_eff;
    logic [FAN_W-1:0]     fanout;

    // handshake and submodule links
    logic                 req_xfer;
    logic [IDX_W-1:0]     upd_idx;
    buf_wr_t              buf_wr;
    buf_rd_t              buf_rd;
    logic [BUF_BITS-1:0]  buf_rd_data;
    div_req_t             div_req;
    div_rsp_t             div_rsp;

    // route setup terms
    logic                 src_in, dst_in, go_down, range_bad;
    logic [NODE_BITS-1:0] abs_off;
    logic [NODE_BITS-1:0] span;
    logic                 q_err;
    logic                 vc_last, port_last;
    logic [SUM_W-1:0]     rd_val, port_sum;

    assign cfg_ready = 1'b1;

    // config writes; indexes past the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_ports_reg   <= NPORT_W'(8);
            vcs_reg         <= NVC_W'(1);
            adaptive_reg    <= 1'b0;
            ibuf_reg        <= 1'b0;
            range_start_reg <= '0;
            range_end_reg   <= NODE_BITS'(16);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_NUM_PORTS:       num_ports_reg   <= cfg_data[NPORT_W-1:0];
                CFG_VCS_PER_PORT:    vcs_reg         <= cfg_data[NVC_W-1:0];
                CFG_ADAPTIVE_MODE:   adaptive_reg    <= cfg_data[0];
                CFG_INPUT_BUFFERING: ibuf_reg        <= cfg_data[0];
                CFG_RANGE_START:     range_start_reg <= cfg_data[NODE_BITS-1:0];
                CFG_RANGE_END:       range_end_reg   <= cfg_data[NODE_BITS-1:0];
                default:             ;
            endcase
        end
    end

    // saturate port and channel counts
    always_comb
    begin
        if (num_ports_reg < NPORT_W'(2))
        begin
            ports_eff = NPORT_W'(2);
        end
        else if (num_ports_reg > NPORT_W'(MAX_PORTS))
        begin
            ports_eff = NPORT_W'(MAX_PORTS);
        end
        else
        begin
            ports_eff = num_ports_reg;
        end

        if (vcs_reg < NVC_W'(1))
        begin
            vcs_eff = NVC_W'(1);
        end
        else if (vcs_reg > NVC_W'(MAX_VCS))
        begin
            vcs_eff = NVC_W'(MAX_VCS);
        end
        else
        begin
            vcs_eff = vcs_reg;
        end

        fanout = ports_eff[NPORT_W-1:1];
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign req_xfer  = req_valid && !req_stall;

    // buffer count writes happen right at the update transfer
    always_comb
    begin
        upd_idx = IDX_W'(req_data.upd_port) * IDX_W'(vcs_eff) + IDX_W'(req_data.upd_vc);
        buf_wr.en   = req_xfer && (req_data.opcode == OP_UPDATE)
                      && ({1'b0, req_data.upd_vc} < vcs_eff)
                      && (upd_idx < IDX_W'(BUF_DEPTH));
        buf_wr.addr = upd_idx[ADDR_W-1:0];
        buf_wr.data = req_data.upd_value;
    end

    ftrps_buf_store u_buf_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (buf_wr),
        .rd      (buf_rd),
        .rd_data (buf_rd_data)
    );

    ftrps_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // route setup terms, from the latched item
    always_comb
    begin
        src_in    = (item_reg.src_node >= range_start_reg)
                    && (item_reg.src_node < range_end_reg);
        dst_in    = (item_reg.dst_node >= range_start_reg)
                    && (item_reg.dst_node < range_end_reg);
        go_down   = (src_in && dst_in) || (item_reg.in_port >= fanout);
        range_bad = (range_end_reg <= range_start_reg);
        abs_off   = (item_reg.dst_node < range_start_reg)
                    ? (range_start_reg - item_reg.dst_node)
                    : (item_reg.dst_node - range_start_reg);
        span      = range_end_reg - range_start_reg;
        // a negative offset truncates to port 0 only when the quotient is zero
        q_err     = neg_reg ? (div_rsp.quotient != '0)
                            : (div_rsp.quotient >= DIVIDEND_W'(fanout));
        vc_last   = ({1'b0, scan_vc_reg} == (vcs_eff - NVC_W'(1)));
        port_last = ({1'b0, scan_port_reg} == (ports_eff - NPORT_W'(1)));
    end

    // scan result stage: data of the read issued last cycle
    always_comb
    begin
        rd_val         = SUM_W'(buf_rd_data);
        port_sum       = (tag_reg.first_vc ? '0 : acc_reg) + rd_val;
        acc_next       = acc_reg;
        best_next      = best_reg;
        best_port_next = best_port_reg;
        if (tag_reg.valid)
        begin
            priority if (tag_reg.cand)
            begin
                best_next      = rd_val;
                best_port_next = tag_reg.port;
            end
            else if (!ibuf_reg)
            begin
                acc_next = port_sum;
                // ties keep the earlier port
                if (tag_reg.last_vc && (port_sum > best_reg))
                begin
                    best_next      = port_sum;
                    best_port_next = tag_reg.port;
                end
            end
            else
            begin
                if (rd_val > best_reg)
                begin
                    best_next      = rd_val;
                    best_port_next = tag_reg.port;
                end
            end
        end

        // setup overrides for the sum scan start
        if (state_reg == ST_PREP)
        begin
            best_next      = '0;
            best_port_next = fanout[PORT_W-1:0];
        end
    end

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        item_next        = item_reg;
        tag_next         = '0;
        down_next        = down_reg;
        neg_next         = neg_reg;
        cand_next        = cand_reg;
        scan_port_next   = scan_port_reg;
        scan_vc_next     = scan_vc_reg;
        scan_addr_next   = scan_addr_reg;
        res_port_next    = res_port_reg;
        res_err_next     = res_err_reg;
        buf_rd           = '0;
        div_req          = '0;
        rsp_valid_next   = rsp_valid_reg && rsp_stall;
        rsp_data_next    = rsp_data_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_xfer && (req_data.opcode == OP_ROUTE))
                begin
                    item_next  = req_data;
                    state_next = ST_PREP;
                end
            end

            ST_PREP:
            begin
                scan_port_next = fanout[PORT_W-1:0];
                scan_vc_next   = '0;
                scan_addr_next = ADDR_W'(ADDR_W'(fanout) * ADDR_W'(vcs_eff));
                neg_next       = (item_reg.dst_node < range_start_reg);
                down_next      = go_down;
                priority if (go_down)
                begin
                    if (range_bad)
                    begin
                        res_port_next = '0;
                        res_err_next  = 1'b1;
                        state_next    = ST_DONE;
                    end
                    else
                    begin
                        div_req.start    = 1'b1;
                        div_req.dividend = DIVIDEND_W'(abs_off) * DIVIDEND_W'(fanout);
                        div_req.divisor  = span;
                        state_next       = ST_DIV;
                    end
                end
                else if (!adaptive_reg)
                begin
                    // in_port is below fanout here, so the modulo is the port itself
                    res_port_next = item_reg.in_port + fanout[PORT_W-1:0];
                    res_err_next  = 1'b0;
                    state_next    = ST_DONE;
                end
                else if (!ibuf_reg)
                begin
                    state_next = ST_SCAN;
                end
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = DIVIDEND_W'(item_reg.dst_node);
                    div_req.divisor  = DIVISOR_W'(fanout);
                    state_next       = ST_DIV;
                end
            end

            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    if (down_reg)
                    begin
                        res_port_next = q_err ? '0 : div_rsp.quotient[PORT_W-1:0];
                        res_err_next  = q_err;
                        state_next    = ST_DONE;
                    end
                    else
                    begin
                        cand_next  = div_rsp.remainder[PORT_W-1:0] + fanout[PORT_W-1:0];
                        state_next = ST_CAND;
                    end
                end
            end

            ST_CAND:
            begin
                // first candidate, rated by its channel 0 count
                buf_rd.en     = 1'b1;
                buf_rd.addr   = ADDR_W'(ADDR_W'(cand_reg) * ADDR_W'(vcs_eff));
                tag_next.valid = 1'b1;
                tag_next.cand  = 1'b1;
                tag_next.port  = cand_reg;
                state_next     = ST_SCAN;
            end

            ST_SCAN:
            begin
                buf_rd.en         = 1'b1;
                buf_rd.addr       = scan_addr_reg;
                tag_next.valid    = 1'b1;
                tag_next.port     = scan_port_reg;
                tag_next.first_vc = (scan_vc_reg == '0);
                tag_next.last_vc  = vc_last;
                tag_next.last     = vc_last && port_last;
                scan_addr_next    = scan_addr_reg + 1'b1;
                if (vc_last)
                begin
                    scan_vc_next   = '0;
                    scan_port_next = scan_port_reg + 1'b1;
                end
                else
                begin
                    scan_vc_next = scan_vc_reg + 1'b1;
                end
                if (vc_last && port_last)
                begin
                    state_next = ST_DRAIN;
                end
            end

            ST_DRAIN:
            begin
                // last read is being compared this cycle
                res_port_next = best_port_next;
                res_err_next  = 1'b0;
                state_next    = ST_DONE;
            end

            ST_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next            = 1'b1;
                    rsp_data_next.out_port    = res_port_reg;
                    rsp_data_next.route_error = res_err_reg;
                    state_next                = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            tag_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tag_reg       <= tag_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        down_reg      <= down_next;
        neg_reg       <= neg_next;
        cand_reg      <= cand_next;
        scan_port_reg <= scan_port_next;
        scan_vc_reg   <= scan_vc_next;
        scan_addr_reg <= scan_addr_next;
        acc_reg       <= acc_next;
        best_reg      <= best_next;
        best_port_reg <= best_port_next;
        res_port_reg  <= res_port_next;
        res_err_reg   <= res_err_next;
        rsp_data_reg  <= rsp_data_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    // a route transfer always takes the block busy, an update never does
    `FTRPS_ASSERT_NEXT(a_route_busy, req_xfer && (req_data.opcode == OP_ROUTE), req_stall)
    `FTRPS_ASSERT_NEXT(a_update_free, req_xfer && (req_data.opcode == OP_UPDATE), !req_stall)
    // an error result always points at port 0
    `FTRPS_ASSERT_NOW(a_err_port, rsp_valid && rsp_data.route_error, rsp_data.out_port == '0)
    // the divider only runs while the sequencer waits on it
    `FTRPS_ASSERT_NOW(a_div_owner, div_rsp.busy, state_reg == ST_DIV)
    // buffer read data only comes back during the scan
    `FTRPS_ASSERT_NOW(a_scan_tag, tag_reg.valid, (state_reg == ST_SCAN) || (state_reg == ST_DRAIN))

endmodule

>>> rtl/ftrps_buf_store.sv
// free-buffer count store, one write and one registered read port
module ftrps_buf_store
    import ftrps_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  buf_wr_t             wr,
    input  buf_rd_t             rd,
    output logic [BUF_BITS-1:0] rd_data
);

    logic [BUF_BITS-1:0]  mem [BUF_DEPTH];
    logic [BUF_BITS-1:0]  rd_q_reg;
    logic [BUF_DEPTH-1:0] valid_reg;
    logic                 rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd.en)
        begin
            rd_q_reg <= mem[rd.addr];
        end
    end

    // entries never written read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
            if (rd.en)
            begin
                rd_vld_reg <= valid_reg[rd.addr];
            end
        end
    end

    assign rd_data = rd_vld_reg ? rd_q_reg : '0;

endmodule

>>> rtl/ftrps_div.sv
// shared restoring divider, one quotient bit per cycle
module ftrps_div
    import ftrps_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam logic [DIV_CNT_W-1:0] DIV_STEPS = DIV_CNT_W'(DIVIDEND_W);

    logic                  busy_reg;
    logic                  done_reg;
    logic [DIV_CNT_W-1:0]  cnt_reg;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  divisor_reg;

    logic [DIVISOR_W:0]    shifted;
    logic [DIVISOR_W:0]    diff;
    logic                  ge;

    always_comb
    begin
        shifted = {rem_reg, quo_reg[DIVIDEND_W-1]};
        diff    = shifted - {1'b0, divisor_reg};
        ge      = (shifted >= {1'b0, divisor_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= DIV_STEPS;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg     <= req.dividend;
            rem_reg     <= '0;
            divisor_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], ge};
            rem_reg <= ge ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
        end
    end

    assign rsp.busy      = busy_reg;
    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule
